### design/ecnpv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecnpv_pkg: shared types and constants for the ECN path validator
// Event and result transaction types, command and status codes, ECN
// codepoints and the saturating counter helper.
// ----------------------------------------------------------------------------
package ecnpv_pkg;

    localparam int CNT_W   = 62;
    localparam int SUM_W   = CNT_W + 2;
    localparam int MARK_W  = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // ECN codepoints
    localparam logic [MARK_W-1:0] MARK_NONE = 2'd0;
    localparam logic [MARK_W-1:0] MARK_ECT1 = 2'd1;
    localparam logic [MARK_W-1:0] MARK_ECT0 = 2'd2;

    typedef enum logic [1:0] {
        CMD_SENT    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_DISABLE = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FAILED_NOW = 2'd1,
        ST_IGNORED    = 2'd2
    } status_t;

    // one input event
    typedef struct packed {
        cmd_t              cmd;
        logic [MARK_W-1:0] sent_marking;
        logic [CNT_W-1:0]  ack_ect0;
        logic [CNT_W-1:0]  ack_ect1;
        logic [CNT_W-1:0]  ack_ce;
    } event_t;

    // one result
    typedef struct packed {
        status_t           status;
        logic [CNT_W-1:0]  new_ce;
        logic              congestion;
        logic [MARK_W-1:0] out_marking;
        logic              is_capable;
        logic              is_testing;
        logic              is_failed;
    } result_t;

    // increment that holds at the counter maximum
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == CNT_MAX) begin
            r = v;
        end else begin
            r = v + {{(CNT_W-1){1'b0}}, 1'b1};
        end
        return r;
    endfunction

endpackage

### design/ecn_path_validator.sv
`timescale 1ns / 1ps
// Path: an accepted s_ event is captured in the input register, then moves to the
//   result register (raising m_valid) once that register is free; m_ stalls hold it.
// Throughput: one event per cycle unless m_ stalls; state and result load together.
// Reset: synchronous, active low; counters clear, path returns to testing
//   with ECT(0) marking, both register stages empty.
// ----------------------------------------------------------------------------
// ecn_path_validator: per-path ECN validation
// Counts sent ECT packets, validates peer ACK ECN counts and reports
// CE increase, congestion and the marking for outgoing packets.
// ----------------------------------------------------------------------------
module ecn_path_validator
    import ecnpv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic [MARK_W-1:0] s_sent_marking,
    input  logic [CNT_W-1:0]  s_ack_ect0,
    input  logic [CNT_W-1:0]  s_ack_ect1,
    input  logic [CNT_W-1:0]  s_ack_ce,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [CNT_W-1:0]  m_new_ce,
    output logic              m_congestion,
    output logic [MARK_W-1:0] m_out_marking,
    output logic              m_is_capable,
    output logic              m_is_testing,
    output logic              m_is_failed
);

    event_t  s_event;
    event_t  in_event;
    logic    in_valid;
    logic    out_free;
    logic    fire;
    result_t eng_res;
    result_t out_res;

    assign s_event.cmd          = cmd_t'(s_cmd);
    assign s_event.sent_marking = s_sent_marking;
    assign s_event.ack_ect0     = s_ack_ect0;
    assign s_event.ack_ect1     = s_ack_ect1;
    assign s_event.ack_ce       = s_ack_ce;

    // event moves into state and result register together
    assign fire = in_valid && out_free;

    ecnpv_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_event  (s_event),
        .out_valid (in_valid),
        .out_take  (fire),
        .out_event (in_event)
    );

    ecnpv_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .ev      (in_event),
        .res     (eng_res)
    );

    ecnpv_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .can_load (out_free),
        .in_res   (eng_res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .out_res  (out_res)
    );

    assign m_status      = out_res.status;
    assign m_new_ce      = out_res.new_ce;
    assign m_congestion  = out_res.congestion;
    assign m_out_marking = out_res.out_marking;
    assign m_is_capable  = out_res.is_capable;
    assign m_is_testing  = out_res.is_testing;
    assign m_is_failed   = out_res.is_failed;

    // restart lands a testing, non-failed result
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (in_event.cmd == CMD_RESTART) |=> m_valid && m_is_testing && !m_is_failed)
        else $error("restart did not return path to testing");

    // disable lands a failed result with no marking
    a_disable: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (in_event.cmd == CMD_DISABLE) |=>
            m_valid && m_is_failed && (m_out_marking == MARK_NONE))
        else $error("disable did not fail the path");

    // rejected or ignored ACKs carry no CE increase
    a_no_ce: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_new_ce == '0) && !m_congestion)
        else $error("CE increase reported on a rejected ACK");

    // failed path never capable and never marks
    a_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_failed |-> !m_is_capable && !m_is_testing &&
            (m_out_marking == MARK_NONE))
        else $error("failed path still active");

endmodule

### design/ecnpv_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecnpv_in_stage: input register
// Captures one event transaction and holds it until the engine consumes it.
// ----------------------------------------------------------------------------
module ecnpv_in_stage
    import ecnpv_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  event_t in_event,
    output logic   out_valid,
    input  logic   out_take,
    output event_t out_event
);

    logic   valid_reg;
    logic   valid_next;
    event_t event_reg;
    logic   load;

    // free, or emptied by the consumer in this cycle
    assign in_ready = !valid_reg || out_take;
    assign load     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            event_reg <= in_event;
        end
    end

    assign out_valid = valid_reg;
    assign out_event = event_reg;

endmodule

### design/ecnpv_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecnpv_engine: path state and validation logic
// Holds sent/acked counters and path flags, checks ACK reports and
// forms the result from the state after the event.
// ----------------------------------------------------------------------------
module ecnpv_engine
    import ecnpv_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  event_t  ev,
    output result_t res
);

    logic [CNT_W-1:0]  e0_sent_reg,  e0_sent_next;
    logic [CNT_W-1:0]  e1_sent_reg,  e1_sent_next;
    logic [CNT_W-1:0]  e0_acked_reg, e0_acked_next;
    logic [CNT_W-1:0]  e1_acked_reg, e1_acked_next;
    logic [CNT_W-1:0]  ce_acked_reg, ce_acked_next;
    logic              testing_reg,  testing_next;
    logic              capable_reg,  capable_next;
    logic              failed_reg,   failed_next;
    logic [MARK_W-1:0] marking_reg,  marking_next;

    logic [SUM_W-1:0]  sent_sum;
    logic [SUM_W-1:0]  acked_sum;
    logic              count_drop;
    status_t           status;
    logic [CNT_W-1:0]  new_ce;

    // ACK checks, all in parallel
    assign sent_sum   = {2'b00, e0_sent_reg} + {2'b00, e1_sent_reg};
    assign acked_sum  = {2'b00, ev.ack_ect0} + {2'b00, ev.ack_ect1} + {2'b00, ev.ack_ce};
    assign count_drop = (ev.ack_ect0 < e0_acked_reg) || (ev.ack_ect1 < e1_acked_reg) ||
                        (ev.ack_ce < ce_acked_reg);

    // next state
    always_comb begin
        e0_sent_next  = e0_sent_reg;
        e1_sent_next  = e1_sent_reg;
        e0_acked_next = e0_acked_reg;
        e1_acked_next = e1_acked_reg;
        ce_acked_next = ce_acked_reg;
        testing_next  = testing_reg;
        capable_next  = capable_reg;
        failed_next   = failed_reg;
        marking_next  = marking_reg;
        status        = ST_OK;
        new_ce        = '0;
        unique case (ev.cmd)
            CMD_SENT: begin
                if (ev.sent_marking == MARK_ECT0) begin
                    e0_sent_next = sat_inc(e0_sent_reg);
                end else if (ev.sent_marking == MARK_ECT1) begin
                    e1_sent_next = sat_inc(e1_sent_reg);
                end
            end
            CMD_ACK: begin
                if (failed_reg) begin
                    status = ST_IGNORED;
                end else if (count_drop || (acked_sum > sent_sum)) begin
                    failed_next  = 1'b1;
                    testing_next = 1'b0;
                    capable_next = 1'b0;
                    status       = ST_FAILED_NOW;
                end else begin
                    new_ce        = ev.ack_ce - ce_acked_reg;
                    e0_acked_next = ev.ack_ect0;
                    e1_acked_next = ev.ack_ect1;
                    ce_acked_next = ev.ack_ce;
                    // first non-empty report ends testing
                    if (testing_reg && (acked_sum != '0)) begin
                        capable_next = 1'b1;
                        testing_next = 1'b0;
                    end
                end
            end
            CMD_DISABLE: begin
                failed_next  = 1'b1;
                testing_next = 1'b0;
                capable_next = 1'b0;
                marking_next = MARK_NONE;
            end
            CMD_RESTART: begin
                e0_sent_next  = '0;
                e1_sent_next  = '0;
                e0_acked_next = '0;
                e1_acked_next = '0;
                ce_acked_next = '0;
                testing_next  = 1'b1;
                capable_next  = 1'b0;
                failed_next   = 1'b0;
                marking_next  = MARK_ECT0;
            end
            default: begin
            end
        endcase
    end

    // result reflects state after the event
    always_comb begin
        res.status      = status;
        res.new_ce      = new_ce;
        res.congestion  = (new_ce != '0);
        res.is_capable  = capable_next && !failed_next;
        res.is_testing  = testing_next;
        res.is_failed   = failed_next;
        if (failed_next) begin
            res.out_marking = MARK_NONE;
        end else if (capable_next || testing_next) begin
            res.out_marking = marking_next;
        end else begin
            res.out_marking = MARK_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e0_sent_reg  <= '0;
            e1_sent_reg  <= '0;
            e0_acked_reg <= '0;
            e1_acked_reg <= '0;
            ce_acked_reg <= '0;
            testing_reg  <= 1'b1;
            capable_reg  <= 1'b0;
            failed_reg   <= 1'b0;
            marking_reg  <= MARK_ECT0;
        end else if (fire) begin
            e0_sent_reg  <= e0_sent_next;
            e1_sent_reg  <= e1_sent_next;
            e0_acked_reg <= e0_acked_next;
            e1_acked_reg <= e1_acked_next;
            ce_acked_reg <= ce_acked_next;
            testing_reg  <= testing_next;
            capable_reg  <= capable_next;
            failed_reg   <= failed_next;
            marking_reg  <= marking_next;
        end
    end

endmodule

### design/ecnpv_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecnpv_out_stage: result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module ecnpv_out_stage
    import ecnpv_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    output logic    can_load,
    input  result_t in_res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // empty, or drained in this cycle
    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= in_res;
        end
    end

    assign m_valid = valid_reg;
    assign out_res = res_reg;

endmodule

### sim/tb_ecn_path_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ecn_path_validator: self-checking testbench for the ECN path validator
// A directed table walks the edge cases of the validation rules, then random
// event streams follow: mostly well-formed send/ACK sequences, mixed with
// bad ACK reports, disables and restarts. Every result transaction is
// compared field by field with an in-bench path model or a row's fixed want.
// ----------------------------------------------------------------------------
module tb_ecn_path_validator;
    import ecnpv_pkg::*;

    localparam int RANDOM_EVENTS = 2000;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_IDLE      = 11;
    localparam logic [MARK_W-1:0] MARK_CE = 2'd3;

    // one row of the directed table; want is used only when has_want is set
    typedef struct packed {
        event_t  ev;
        logic    has_want;
        result_t want;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_cmd;
    logic [MARK_W-1:0] s_sent_marking;
    logic [CNT_W-1:0]  s_ack_ect0;
    logic [CNT_W-1:0]  s_ack_ect1;
    logic [CNT_W-1:0]  s_ack_ce;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_status;
    logic [CNT_W-1:0]  m_new_ce;
    logic              m_congestion;
    logic [MARK_W-1:0] m_out_marking;
    logic              m_is_capable;
    logic              m_is_testing;
    logic              m_is_failed;

    // model of the path state
    logic [CNT_W-1:0]  sent_e0;
    logic [CNT_W-1:0]  sent_e1;
    logic [CNT_W-1:0]  acked_e0;
    logic [CNT_W-1:0]  acked_e1;
    logic [CNT_W-1:0]  acked_ce;
    logic              path_testing;
    logic              path_capable;
    logic              path_failed;
    logic              path_validated;
    logic [MARK_W-1:0] path_mark;

    result_t   expected_results[$];
    stim_row_t directed_rows[$];
    int        error_count  = 0;
    int        stall_cycles = 0;
    bit        src_calm     = 1'b0;
    bit        sink_calm    = 1'b0;

    ecn_path_validator DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_sent_marking (s_sent_marking),
        .s_ack_ect0     (s_ack_ect0),
        .s_ack_ect1     (s_ack_ect1),
        .s_ack_ce       (s_ack_ce),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_new_ce       (m_new_ce),
        .m_congestion   (m_congestion),
        .m_out_marking  (m_out_marking),
        .m_is_capable   (m_is_capable),
        .m_is_testing   (m_is_testing),
        .m_is_failed    (m_is_failed)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // --------------------------------------------------------------------
    // path state model
    // --------------------------------------------------------------------
    function automatic void path_state_clear();
        sent_e0        = '0;
        sent_e1        = '0;
        acked_e0       = '0;
        acked_e1       = '0;
        acked_ce       = '0;
        path_testing   = 1'b1;
        path_capable   = 1'b0;
        path_failed    = 1'b0;
        path_validated = 1'b0;
        path_mark      = MARK_ECT0;
    endfunction

    function automatic void path_fail();
        path_failed  = 1'b1;
        path_testing = 1'b0;
        path_capable = 1'b0;
    endfunction

    // sent counters stick at all-ones
    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // apply one event to the model and return the result it produces
    function automatic result_t ecn_predict(input event_t ev);
        result_t          r;
        logic [SUM_W-1:0] sent_sum;
        logic [SUM_W-1:0] ack_sum;
        r        = '0;
        r.status = ST_OK;
        sent_sum = {2'b00, sent_e0} + {2'b00, sent_e1};
        ack_sum  = {2'b00, ev.ack_ect0} + {2'b00, ev.ack_ect1} + {2'b00, ev.ack_ce};
        case (ev.cmd)
            CMD_SENT: begin
                if (ev.sent_marking == MARK_ECT0) begin
                    sent_e0 = count_up(sent_e0);
                end else if (ev.sent_marking == MARK_ECT1) begin
                    sent_e1 = count_up(sent_e1);
                end
            end
            CMD_ACK: begin
                if (path_failed) begin
                    r.status = ST_IGNORED;
                end else if (ev.ack_ect0 < acked_e0 || ev.ack_ect1 < acked_e1 ||
                             ev.ack_ce < acked_ce || ack_sum > sent_sum) begin
                    path_fail();
                    r.status = ST_FAILED_NOW;
                end else begin
                    r.new_ce = ev.ack_ce - acked_ce;
                    acked_e0 = ev.ack_ect0;
                    acked_e1 = ev.ack_ect1;
                    acked_ce = ev.ack_ce;
                    if (path_testing && ack_sum != 0) begin
                        path_validated = 1'b1;
                        path_capable   = 1'b1;
                        path_testing   = 1'b0;
                    end
                end
            end
            CMD_DISABLE: begin
                path_fail();
                path_mark = MARK_NONE;
            end
            CMD_RESTART: begin
                path_state_clear();
            end
        endcase
        r.congestion  = (r.new_ce != 0);
        r.out_marking = (!path_failed && (path_capable || path_testing)) ? path_mark
                                                                        : MARK_NONE;
        r.is_capable  = path_capable && !path_failed;
        r.is_testing  = path_testing;
        r.is_failed   = path_failed;
        return r;
    endfunction

    // --------------------------------------------------------------------
    // stimulus helpers
    // --------------------------------------------------------------------
    function automatic result_t fixed_result(input status_t st, input logic [MARK_W-1:0] mk,
                                             input logic cap, input logic tst,
                                             input logic fl);
        result_t r;
        r             = '0;
        r.status      = st;
        r.out_marking = mk;
        r.is_capable  = cap;
        r.is_testing  = tst;
        r.is_failed   = fl;
        return r;
    endfunction

    task automatic add_row(input cmd_t c, input logic [MARK_W-1:0] mk,
                           input logic [CNT_W-1:0] a0, input logic [CNT_W-1:0] a1,
                           input logic [CNT_W-1:0] ac, input logic has_want,
                           input result_t want);
        stim_row_t row;
        row.ev.cmd          = c;
        row.ev.sent_marking = mk;
        row.ev.ack_ect0     = a0;
        row.ev.ack_ect1     = a1;
        row.ev.ack_ce       = ac;
        row.has_want        = has_want;
        row.want            = want;
        directed_rows.push_back(row);
    endtask

    function automatic logic [CNT_W-1:0] rand_count();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] noise_count();
        return ($urandom_range(0, 1) != 0) ? rand_count() : CNT_W'($urandom_range(0, 3));
    endfunction

    // draw the next random event from the current model state, so most ACKs
    // are consistent with what has been sent and acknowledged so far
    task automatic make_random_event(output event_t ev);
        int unsigned      pick;
        int unsigned      room;
        int unsigned      d0;
        int unsigned      d1;
        int unsigned      dc;
        int unsigned      lane;
        logic [SUM_W-1:0] headroom;
        logic [CNT_W-1:0] stored;
        ev.cmd          = CMD_SENT;
        ev.sent_marking = MARK_W'($urandom_range(0, 3));
        ev.ack_ect0     = noise_count();
        ev.ack_ect1     = noise_count();
        ev.ack_ce       = noise_count();
        pick     = $urandom_range(0, 99);
        headroom = {2'b00, sent_e0} + {2'b00, sent_e1} - {2'b00, acked_e0}
                   - {2'b00, acked_e1} - {2'b00, acked_ce};
        room     = headroom[31:0];
        if (path_failed) begin
            // sometimes recover, mostly poke the failed path
            if (pick < 30) begin
                ev.cmd = CMD_RESTART;
            end else if (pick < 70) begin
                ev.cmd = CMD_SENT;
            end else if (pick < 90) begin
                ev.cmd = CMD_ACK;
            end else begin
                ev.cmd = CMD_DISABLE;
            end
        end else if (pick < 50) begin
            ev.cmd = CMD_SENT;
            if ($urandom_range(0, 4) != 0) begin
                ev.sent_marking = ($urandom_range(0, 1) != 0) ? MARK_ECT0 : MARK_ECT1;
            end
        end else if (pick < 85) begin
            // consistent ACK: counts never go down, sum within what was sent
            ev.cmd      = CMD_ACK;
            d0          = $urandom_range(0, room);
            room        = room - d0;
            d1          = $urandom_range(0, room);
            room        = room - d1;
            dc          = ($urandom_range(0, 1) != 0) ? room : $urandom_range(0, room);
            ev.ack_ect0 = acked_e0 + d0;
            ev.ack_ect1 = acked_e1 + d1;
            ev.ack_ce   = acked_ce + dc;
        end else if (pick < 93) begin
            // bad ACK: a count going down, a sum too large, or garbage
            ev.cmd      = CMD_ACK;
            ev.ack_ect0 = acked_e0;
            ev.ack_ect1 = acked_e1;
            ev.ack_ce   = acked_ce;
            lane        = $urandom_range(0, 2);
            case (lane)
                0: stored = acked_e0;
                1: stored = acked_e1;
                default: stored = acked_ce;
            endcase
            pick = $urandom_range(0, 2);
            if (pick == 0 && stored != 0) begin
                stored = CNT_W'($urandom_range(0, stored[31:0] - 1));
            end else if (pick <= 1) begin
                stored = stored + room + $urandom_range(1, 3);
            end else begin
                stored = rand_count();
            end
            case (lane)
                0: ev.ack_ect0 = stored;
                1: ev.ack_ect1 = stored;
                default: ev.ack_ce = stored;
            endcase
        end else if (pick < 96) begin
            ev.cmd = CMD_DISABLE;
        end else begin
            ev.cmd = CMD_RESTART;
        end
    endtask

    // present one event, wait for its transaction, record the expected result
    task automatic issue_event(input event_t ev, input logic has_want, input result_t want);
        int unsigned gap;
        result_t     pred;
        if ($urandom_range(0, 39) == 0) begin
            src_calm = ~src_calm;
        end
        gap = src_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= ev.cmd;
        s_sent_marking <= ev.sent_marking;
        s_ack_ect0     <= ev.ack_ect0;
        s_ack_ect1     <= ev.ack_ect1;
        s_ack_ce       <= ev.ack_ce;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = ecn_predict(ev);
        expected_results.push_back(has_want ? want : pred);
    endtask

    // --------------------------------------------------------------------
    // main sequence
    // --------------------------------------------------------------------
    initial begin
        result_t   fresh;
        result_t   failed_now;
        result_t   ignored;
        result_t   disabled;
        result_t   none;
        stim_row_t row;
        event_t    ev;

        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_cmd          <= CMD_SENT;
        s_sent_marking <= MARK_NONE;
        s_ack_ect0     <= '0;
        s_ack_ect1     <= '0;
        s_ack_ce       <= '0;
        path_state_clear();

        fresh      = fixed_result(ST_OK, MARK_ECT0, 1'b0, 1'b1, 1'b0);
        failed_now = fixed_result(ST_FAILED_NOW, MARK_NONE, 1'b0, 1'b0, 1'b1);
        ignored    = fixed_result(ST_IGNORED, MARK_NONE, 1'b0, 1'b0, 1'b1);
        disabled   = fixed_result(ST_OK, MARK_NONE, 1'b0, 1'b0, 1'b1);
        none       = '0;

        // uncounted markings and an all-zero ACK leave the reset state alone
        add_row(CMD_SENT,    MARK_NONE, '0, '0, '0, 1'b1, fresh);
        add_row(CMD_SENT,    MARK_CE, CNT_MAX, CNT_MAX, CNT_MAX, 1'b1, fresh);
        add_row(CMD_ACK,     MARK_NONE, '0, '0, '0, 1'b1, fresh);
        // first consistent ACK with CE promotes testing to capable
        add_row(CMD_SENT,    MARK_ECT0, '0, '0, '0, 1'b0, none);
        add_row(CMD_SENT,    MARK_ECT1, '0, '0, '0, 1'b0, none);
        add_row(CMD_SENT,    MARK_ECT0, '0, '0, '0, 1'b0, none);
        add_row(CMD_ACK,     MARK_NONE, 62'd1, 62'd1, 62'd1, 1'b0, none);
        // CE count going backwards fails, later ACKs are ignored
        add_row(CMD_ACK,     MARK_NONE, 62'd1, 62'd1, 62'd0, 1'b1, failed_now);
        add_row(CMD_ACK,     MARK_NONE, CNT_MAX, CNT_MAX, CNT_MAX, 1'b1, ignored);
        add_row(CMD_DISABLE, MARK_NONE, '0, '0, '0, 1'b1, disabled);
        add_row(CMD_RESTART, MARK_NONE, '0, '0, '0, 1'b1, fresh);
        // largest counts: the full-width sum must not wrap
        add_row(CMD_ACK,     MARK_NONE, CNT_MAX, CNT_MAX, CNT_MAX, 1'b1, failed_now);
        add_row(CMD_RESTART, MARK_NONE, CNT_MAX, CNT_MAX, CNT_MAX, 1'b1, fresh);
        // CE-only ACK, a repeated ACK, and a sum exactly equal to sent
        add_row(CMD_SENT,    MARK_ECT0, '0, '0, '0, 1'b0, none);
        add_row(CMD_SENT,    MARK_ECT0, '0, '0, '0, 1'b0, none);
        add_row(CMD_ACK,     MARK_NONE, 62'd0, 62'd0, 62'd2, 1'b0, none);
        add_row(CMD_ACK,     MARK_NONE, 62'd0, 62'd0, 62'd2, 1'b0, none);
        add_row(CMD_SENT,    MARK_ECT1, '0, '0, '0, 1'b0, none);
        add_row(CMD_ACK,     MARK_NONE, 62'd0, 62'd1, 62'd2, 1'b0, none);
        // one more than sent fails
        add_row(CMD_ACK,     MARK_NONE, 62'd0, 62'd2, 62'd2, 1'b1, failed_now);
        add_row(CMD_RESTART, MARK_NONE, '0, '0, '0, 1'b1, fresh);
        add_row(CMD_ACK,     MARK_NONE, '0, CNT_MAX, '0, 1'b1, failed_now);
        // disable twice, then restart back to ECT(0)
        add_row(CMD_DISABLE, MARK_NONE, '0, '0, '0, 1'b1, disabled);
        add_row(CMD_DISABLE, MARK_ECT0, '0, '0, '0, 1'b1, disabled);
        add_row(CMD_RESTART, MARK_NONE, '0, '0, '0, 1'b1, fresh);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            issue_event(row.ev, row.has_want, row.want);
        end

        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            make_random_event(ev);
            issue_event(ev, 1'b0, none);
        end
        s_valid <= 1'b0;

        // drain, then give a stray result a chance to show up
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // result side ready with random stalls
    initial begin
        int unsigned gap;
        m_ready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                sink_calm = ~sink_calm;
            end
            gap = sink_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // --------------------------------------------------------------------
    // result check
    // --------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: status %0d new_ce %0d",
                       m_status, m_new_ce);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status",      want.status,      m_status);
                check_field("new_ce",      want.new_ce,      m_new_ce);
                check_field("congestion",  want.congestion,  m_congestion);
                check_field("out_marking", want.out_marking, m_out_marking);
                check_field("is_capable",  want.is_capable,  m_is_capable);
                check_field("is_testing",  want.is_testing,  m_is_testing);
                check_field("is_failed",   want.is_failed,   m_is_failed);
            end
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

### ecn_path_validator.f
design/ecnpv_pkg.sv
design/ecnpv_in_stage.sv
design/ecnpv_engine.sv
design/ecnpv_out_stage.sv
design/ecn_path_validator.sv
sim/tb_ecn_path_validator.sv
